// ----- rtl/max_priority_queue_assert.svh -----
// Assertion macros for the max priority queue RTL.
// Assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef MAX_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH

// Condition holds at every clock edge out of reset.
`define MPQ_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("max_priority_queue assertion failed");

// Consequence holds in the same cycle as the antecedent.
`define MPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("max_priority_queue assertion failed");

// Consequence holds in the cycle after the antecedent.
`define MPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("max_priority_queue assertion failed");

`else

`define MPQ_ASSERT(label, cond)
`define MPQ_ASSERT_IMP(label, ante, cons)
`define MPQ_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- rtl/mpq_pkg.sv -----
// Shared types and constants for the max priority queue.
// No dependencies; imported by every module of the block.
package mpq_pkg;

    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } cmd_e;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } cell_op_e;

    typedef struct packed {
        cmd_e                     command;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_e                  status;
        logic signed [DATA_W-1:0] popped_value;
        logic [OCC_W-1:0]         occupancy;
    } res_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_e                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- rtl/mpq_cell.sv -----
// One storage cell of the sorted chain.
// Depends on mpq_pkg; exchanges data with both neighbors every cycle.
module mpq_cell
    import mpq_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic                     occupied,
    input  logic                     left_gt,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic                     gt,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Strict compare places a new value behind equal ones, so ties leave
    // in arrival order.
    assign gt   = !occupied || (ctrl.value > data_reg);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (left_gt)
                begin
                    data_next = left_data;
                end
                else if (gt)
                begin
                    data_next = ctrl.value;
                end
            end
            OP_POP:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- rtl/mpq_out_buf.sv -----
// Two-entry result buffer: output register plus skid stage.
// Depends on mpq_pkg for the result struct.
module mpq_out_buf
    import mpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic main_valid_reg;
    logic main_valid_next;
    res_t main_reg;
    res_t main_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_reg;
    res_t skid_next;
    logic take;

    assign take      = main_valid_reg && !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = main_valid_reg;
    assign res       = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                // advance the skid entry; no push can happen while it is held
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- rtl/max_priority_queue.sv -----
// Max priority queue of signed 32-bit values, built as a chain of CAPACITY
// cells kept sorted in descending order, ties in arrival order. An insert
// lands in the first cell that is empty or holds a smaller value; the cells
// behind it shift back one place; a pop takes the head cell, and the whole
// chain shifts forward. Every command finishes in the cycle it is accepted, so
// one command per cycle is taken while cmd_stall is low; its result goes into
// a two-entry output buffer, and cmd_stall rises only when both entries are
// held. Reset clears fill count and buffer valid flags; no clearing pass runs.
// Depends on mpq_pkg, mpq_cell, mpq_out_buf and max_priority_queue_assert.svh.
`include "max_priority_queue_assert.svh"

module max_priority_queue
    import mpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    cell_ctrl_t               ctrl;
    res_t                     result;
    logic                     buf_full;
    logic                     cell_gt   [CAPACITY];
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign cmd_stall  = buf_full;
    assign accept     = cmd_valid && !cmd_stall;
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign is_empty   = (count_reg == '0);

    always_comb
    begin
        ctrl.value = cmd.value;
        ctrl.op    = OP_HOLD;
        count_next = count_reg;
        result.status       = ST_INSERTED;
        result.popped_value = '0;
        if (cmd.command == CMD_INSERT)
        begin
            if (is_full)
            begin
                result.status = ST_OVERFLOW;
            end
            else
            begin
                ctrl.op    = accept ? OP_INSERT : OP_HOLD;
                count_next = accept ? count_reg + 1'b1 : count_reg;
            end
        end
        else
        begin
            if (is_empty)
            begin
                result.status = ST_EMPTY;
            end
            else
            begin
                result.status       = ST_POPPED;
                result.popped_value = cell_data[0];
                ctrl.op    = accept ? OP_POP : OP_HOLD;
                count_next = accept ? count_reg - 1'b1 : count_reg;
            end
        end
        result.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     left_gt;
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_head
            assign left_gt   = 1'b0;
            assign left_data = '0;
        end
        else
        begin : g_body
            assign left_gt   = cell_gt[i-1];
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_data = '0;
        end
        else
        begin : g_link
            assign right_data = cell_data[i+1];
        end

        mpq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (CW'(i) < count_reg),
            .left_gt    (left_gt),
            .left_data  (left_data),
            .right_data (right_data),
            .gt         (cell_gt[i]),
            .data       (cell_data[i])
        );
    end

    mpq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    `MPQ_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY))
    `MPQ_ASSERT_NXT(a_insert_count, ctrl.op == OP_INSERT, count_reg == $past(count_reg) + 1'b1)
    `MPQ_ASSERT_NXT(a_result_follows, accept, res_valid)
    `MPQ_ASSERT_IMP(a_stall_when_full, cmd_stall, res_valid)

    for (genvar j = 0; j < CAPACITY - 1; j++)
    begin : g_sorted_chk
        `MPQ_ASSERT_IMP(a_sorted, CW'(j + 1) < count_reg, cell_data[j] >= cell_data[j+1])
    end

endmodule
